>>> hw/rtl/skht_pkg.sv
// Package for the string key hash table: field widths, request and status
// codes, hash constants and default sizes. No dependencies.
`default_nettype none

package skht_pkg;

  localparam int TABLE_SLOTS_DEF = 97;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int HANDLE_BITS_DEF = 32;

  localparam int KEY_W    = 64;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;
  localparam int HOUT_W   = 32;
  localparam int HIN_W    = 32;

  localparam int HASH_W        = 32;
  localparam int HASH_SHIFT_LO = 6;
  localparam int HASH_SHIFT_HI = 16;
  localparam logic [HASH_W-1:0] HASH_MASK = 32'h7fff_ffff;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_DUPLICATE = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/skht_home_unit.sv
// Home slot unit: normalizes a name and hashes it one byte per cycle, then
// reduces the masked hash modulo the slot count by a reciprocal multiply.
// Depends on skht_pkg.
`default_nettype none

module skht_home_unit #(
  parameter int TABLE_SLOTS = skht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = skht_pkg::KEY_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [skht_pkg::KEY_W-1:0]   raw_key,
  output logic                              done,
  output logic [skht_pkg::KEY_W-1:0]        norm_key,
  output logic [$clog2(TABLE_SLOTS)-1:0]    home
);

  localparam int LOC_W  = $clog2(TABLE_SLOTS);
  localparam int HB_W   = skht_pkg::HASH_W - 1;
  localparam int PROD_W = 2 * HB_W + 1;
  localparam int RCP_SH = HB_W + LOC_W;
  localparam int Q_W    = PROD_W - RCP_SH;
  localparam logic [skht_pkg::KEY_W-1:0] KEY_KEEP =
    ~({skht_pkg::KEY_W{1'b1}} >> (8 * KEY_BYTES));
  // The rounded-up reciprocal gives the exact quotient for every 31-bit
  // masked hash, since its rounding error stays below the slot count.
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [HB_W:0] RECIP = RCP_FULL[HB_W:0];

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_HASH = 5'b00010,
    H_MUL  = 5'b00100,
    H_FOLD = 5'b01000,
    H_SUB  = 5'b10000
  } hstate_t;

  hstate_t                        state_r, state_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic                           ended_r, ended_nxt;
  logic [skht_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [skht_pkg::HASH_W-1:0]    h_r, h_nxt;
  logic [PROD_W-1:0]              prod_r, prod_nxt;
  logic [LOC_W-1:0]               qd_r, qd_nxt;
  logic [Q_W-1:0]                 quot;
  logic [7:0]                     cur_byte;
  logic [skht_pkg::HASH_W-1:0]    h_step;

  always_comb begin
    cur_byte = '0;
    for (int b = 0; b < 8; b++) begin
      if (cnt_r == 3'(b)) begin
        cur_byte = key_r[skht_pkg::KEY_W-1-8*b -: 8];
      end
    end
    h_step = {24'b0, cur_byte} + (h_r << skht_pkg::HASH_SHIFT_LO)
           + (h_r << skht_pkg::HASH_SHIFT_HI) - h_r;
  end

  assign quot = prod_r[PROD_W-1:RCP_SH];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    key_nxt   = key_r;
    h_nxt     = h_r;
    prod_nxt  = prod_r;
    qd_nxt    = qd_r;
    done      = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (go) begin
          state_nxt = H_HASH;
          cnt_nxt   = '0;
          ended_nxt = 1'b0;
          key_nxt   = raw_key & KEY_KEEP;
          h_nxt     = '0;
        end
      end
      H_HASH: begin
        if (ended_r || cur_byte == 8'd0) begin
          ended_nxt = 1'b1;
          for (int b = 0; b < 8; b++) begin
            if (cnt_r == 3'(b)) begin
              key_nxt[skht_pkg::KEY_W-1-8*b -: 8] = 8'd0;
            end
          end
        end else begin
          h_nxt = h_step;
        end
        if (cnt_r == 3'(KEY_BYTES - 1)) begin
          state_nxt = H_MUL;
          cnt_nxt   = '0;
          h_nxt     = h_nxt & skht_pkg::HASH_MASK;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      H_MUL: begin
        prod_nxt  = {{(PROD_W-HB_W){1'b0}}, h_r[HB_W-1:0]}
                  * {{(PROD_W-HB_W-1){1'b0}}, RECIP};
        state_nxt = H_FOLD;
      end
      H_FOLD: begin
        // Only the low bits of quotient times slot count reach the remainder.
        qd_nxt    = quot[LOC_W-1:0] * LOC_W'(TABLE_SLOTS);
        state_nxt = H_SUB;
      end
      H_SUB: begin
        state_nxt = H_IDLE;
        done      = 1'b1;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  assign norm_key = key_r;
  assign home     = h_r[LOC_W-1:0] - qd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    ended_r <= ended_nxt;
    key_r   <= key_nxt;
    h_r     <= h_nxt;
    prod_r  <= prod_nxt;
    qd_r    <= qd_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/string_key_hash_table.sv
// Top level of the string key hash table: request sequencer, slot memories
// and result register. Depends on skht_pkg and skht_home_unit.
`default_nettype none

// Usage:
// A request beat (in_action, in_key_name, in_handle_in) is taken at a rising
// edge where start is high and busy is low. The block handles one request at
// a time and holds busy high until its result is out. Each request gives one
// result beat: out_status, out_slot_index and out_handle_out stand for
// exactly one cycle with out_valid high. The receiver cannot stall, so the
// result is simply taken at the end of that cycle.
// Sequence: the KEY_BYTES bytes of the name are hashed one byte per cycle, the
// masked hash is reduced modulo TABLE_SLOTS by a reciprocal multiply, a fold
// and a subtract, and then the table is probed one slot per cycle through the
// registered read port of the slot memories. A new request can be taken at
// the edge that ends the result cycle. The unused action code gives its
// result in the cycle after it is taken and never raises busy.
// Reset: after rst_n rises the block sweeps the slot memory to mark every
// slot empty, one slot per cycle, and busy stays high until the sweep has
// passed the last slot, so no request is taken before it is done.

module string_key_hash_table #(
  parameter int TABLE_SLOTS = skht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = skht_pkg::KEY_BYTES_DEF,
  parameter int HANDLE_BITS = skht_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [skht_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [skht_pkg::KEY_W-1:0]     in_key_name,
  input  wire logic [skht_pkg::HIN_W-1:0]     in_handle_in,
  output logic                                out_valid,
  output logic [skht_pkg::STATUS_W-1:0]       out_status,
  output logic [skht_pkg::SLOT_W-1:0]         out_slot_index,
  output logic [skht_pkg::HOUT_W-1:0]         out_handle_out
);

  localparam int LOC_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int KM_W  = skht_pkg::KEY_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HOME  = 4'b0100,
    ST_PROBE = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [LOC_W-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [LOC_W-1:0]                 loc_r, loc_nxt;
  logic [CNT_W-1:0]                 probes_r, probes_nxt;
  skht_pkg::action_t                action_r, action_nxt;
  logic [HANDLE_BITS-1:0]           handle_r, handle_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [skht_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [skht_pkg::SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [skht_pkg::HOUT_W-1:0]      out_handle_r, out_handle_nxt;

  // Slot memories: used flag with the key, and the handle.
  logic [KM_W-1:0]                  key_mem [TABLE_SLOTS];
  logic [HANDLE_BITS-1:0]           hdl_mem [TABLE_SLOTS];
  logic [KM_W-1:0]                  rd_key_r;
  logic [HANDLE_BITS-1:0]           rd_hdl_r;
  logic                             kw_en, hw_en;
  logic [LOC_W-1:0]                 w_addr;
  logic [KM_W-1:0]                  kw_data;

  logic                             accept;
  logic                             home_go, home_done;
  logic [skht_pkg::KEY_W-1:0]       norm_key;
  logic [LOC_W-1:0]                 home;
  logic                             slot_used, key_hit, last_probe;
  logic [LOC_W-1:0]                 loc_inc;
  logic [LOC_W+skht_pkg::SLOT_W-1:0]       loc_ext;
  logic [HANDLE_BITS+skht_pkg::HOUT_W-1:0] hdl_ext;

  skht_home_unit #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_home (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (home_go),
    .raw_key  (in_key_name),
    .done     (home_done),
    .norm_key (norm_key),
    .home     (home)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign home_go = accept && (in_action != skht_pkg::ACT_NONE);

  assign slot_used  = rd_key_r[KM_W-1];
  assign key_hit    = slot_used && (rd_key_r[skht_pkg::KEY_W-1:0] == norm_key);
  assign last_probe = (probes_r == CNT_W'(TABLE_SLOTS - 1));
  assign loc_inc    = (loc_r == LOC_W'(TABLE_SLOTS - 1)) ? '0 : loc_r + 1'b1;
  assign loc_ext    = {{skht_pkg::SLOT_W{1'b0}}, loc_r};
  assign hdl_ext    = {{skht_pkg::HOUT_W{1'b0}}, rd_hdl_r};

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    loc_nxt        = loc_r;
    probes_nxt     = probes_r;
    action_nxt     = action_r;
    handle_nxt     = handle_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_handle_nxt = out_handle_r;
    kw_en          = 1'b0;
    hw_en          = 1'b0;
    w_addr         = loc_r;
    kw_data        = {1'b1, norm_key};
    case (state_r)
      ST_CLEAR: begin
        kw_en   = 1'b1;
        w_addr  = clr_cnt_r;
        kw_data = '0;
        if (clr_cnt_r == LOC_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          action_nxt = skht_pkg::action_t'(in_action);
          handle_nxt = HANDLE_BITS'(in_handle_in);
          if (in_action == skht_pkg::ACT_NONE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_NOT_FOUND;
            out_slot_nxt   = '0;
            out_handle_nxt = '0;
          end else begin
            state_nxt = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        if (home_done) begin
          state_nxt  = ST_PROBE;
          loc_nxt    = home;
          probes_nxt = '0;
        end
      end
      ST_PROBE: begin
        out_slot_nxt   = '0;
        out_handle_nxt = '0;
        if (action_r == skht_pkg::ACT_INSERT) begin
          if (!slot_used) begin
            kw_en          = 1'b1;
            hw_en          = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_OK;
            out_slot_nxt   = loc_ext[skht_pkg::SLOT_W-1:0];
          end else if (key_hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_DUPLICATE;
          end else if (last_probe) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_FULL;
          end
        end else begin
          if (!slot_used || (!key_hit && last_probe)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_NOT_FOUND;
          end else if (key_hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = skht_pkg::STS_OK;
            out_slot_nxt   = loc_ext[skht_pkg::SLOT_W-1:0];
            if (action_r == skht_pkg::ACT_REMOVE) begin
              // Removal just drops the used flag; no tombstone is left.
              kw_en   = 1'b1;
              kw_data = {1'b0, norm_key};
            end else begin
              out_handle_nxt = hdl_ext[skht_pkg::HOUT_W-1:0];
            end
          end
        end
        if (out_valid_nxt) begin
          state_nxt = ST_IDLE;
        end else begin
          loc_nxt    = loc_inc;
          probes_nxt = probes_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read port follows the next probe address, so the slot under test
  // is always the one registered on the previous edge.
  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[w_addr] <= kw_data;
    end
    if (hw_en) begin
      hdl_mem[w_addr] <= handle_r;
    end
    rd_key_r <= key_mem[loc_nxt];
    rd_hdl_r <= hdl_mem[loc_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    loc_r        <= loc_nxt;
    probes_r     <= probes_nxt;
    action_r     <= action_nxt;
    handle_r     <= handle_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_handle_out = out_handle_r;

`ifndef SYNTH
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != skht_pkg::STS_OK)
      |-> (out_slot_r == '0) && (out_handle_r == '0))
    else $error("failing result carries a nonzero slot or handle");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy || start))
    else $error("result beat without a request in flight");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (probes_r < CNT_W'(TABLE_SLOTS)))
    else $error("probe count ran past one full turn of the table");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action != skht_pkg::ACT_NONE) |=> busy && !out_valid_r)
    else $error("accepted request did not start the sequencer");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for string_key_hash_table: directed and random insert,
// remove, find and unused code requests, checked against a predictor of the probing table.
// Depends on skht_pkg and the string_key_hash_table RTL only.

module tb;

  localparam int SLOTS      = skht_pkg::TABLE_SLOTS_DEF;
  localparam int POOL_SIZE  = 200;
  localparam int CYCLE_CAP  = 1_500_000;
  // Worst request: hashing, modulo, a full turn of probes and the result cycle.
  localparam int SETTLE     = skht_pkg::KEY_BYTES_DEF + skht_pkg::TABLE_SLOTS_DEF + 16;

  // One expected result beat.
  typedef struct {
    skht_pkg::status_t st;
    logic [6:0]        slot;
    logic [31:0]       hnd;
  } table_reply_t;

  // The scoreboard keeps its own copy of the table. Every accepted request is
  // applied to that copy at once, so the expected results queue up in the
  // same order as the block must produce them.
  class hash_table_scoreboard;
    bit           slot_full[SLOTS];
    logic [63:0]  slot_name[SLOTS];
    logic [31:0]  slot_hnd[SLOTS];
    table_reply_t pending[$];
    int           errors;
    int           replies;
    int           act_count[4];
    int           status_seen[4];

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      errors  = 0;
      replies = 0;
      foreach (act_count[i]) act_count[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Cuts the name at its first zero byte and works out its home slot.
    function logic [63:0] trim_name(input logic [63:0] raw, output int unsigned home);
      logic [63:0] name;
      logic [31:0] h;
      logic [31:0] c;
      name = '0;
      h    = '0;
      for (int i = 0; i < skht_pkg::KEY_BYTES_DEF; i++) begin
        c = {24'h0, raw[63-8*i -: 8]};
        if (c == 32'h0) break;
        name[63-8*i -: 8] = c[7:0];
        h = c + (h << skht_pkg::HASH_SHIFT_LO) + (h << skht_pkg::HASH_SHIFT_HI) - h;
      end
      home = (h & skht_pkg::HASH_MASK) % SLOTS;
      return name;
    endfunction

    function void note_request(input skht_pkg::action_t act, input logic [63:0] raw,
                               input logic [31:0] hnd_in);
      table_reply_t want;
      logic [63:0]  name;
      int unsigned  loc;
      name = trim_name(raw, loc);
      want = '{skht_pkg::STS_NOT_FOUND, 7'd0, 32'd0};
      act_count[act]++;
      case (act)
        skht_pkg::ACT_INSERT: begin
          want.st = skht_pkg::STS_FULL;
          for (int n = 0; n < SLOTS; n++) begin
            if (!slot_full[loc]) begin
              slot_full[loc] = 1'b1;
              slot_name[loc] = name;
              slot_hnd[loc]  = hnd_in;
              want = '{skht_pkg::STS_OK, 7'(loc), 32'd0};
              break;
            end
            if (slot_name[loc] == name) begin
              want.st = skht_pkg::STS_DUPLICATE;
              break;
            end
            loc = (loc + 1 == SLOTS) ? 0 : loc + 1;
          end
        end
        skht_pkg::ACT_REMOVE, skht_pkg::ACT_FIND: begin
          for (int n = 0; n < SLOTS; n++) begin
            if (!slot_full[loc]) break;
            if (slot_name[loc] == name) begin
              if (act == skht_pkg::ACT_REMOVE) begin
                slot_full[loc] = 1'b0;
                want = '{skht_pkg::STS_OK, 7'(loc), 32'd0};
              end else begin
                want = '{skht_pkg::STS_OK, 7'(loc), slot_hnd[loc]};
              end
              break;
            end
            loc = (loc + 1 == SLOTS) ? 0 : loc + 1;
          end
        end
        default: begin
        end
      endcase
      pending.push_back(want);
    endfunction

    function void check_reply(input logic [1:0] st, input logic [6:0] slot,
                              input logic [31:0] hnd);
      table_reply_t want;
      replies++;
      if (!$isunknown(st)) status_seen[st]++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result beat: status %0d slot %0d handle %h",
                   st, slot, hnd);
        return;
      end
      want = pending.pop_front();
      if (st !== want.st || slot !== want.slot || hnd !== want.hnd) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: expected status %0d slot %0d handle %h, got status %0d slot %0d handle %h",
                   replies, want.st, want.slot, want.hnd, st, slot, hnd);
      end
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  in_action      = '0;
  logic [63:0] in_key_name    = '0;
  logic [31:0] in_handle_in   = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [6:0]  out_slot_index;
  logic [31:0] out_handle_out;

  hash_table_scoreboard sb = new();

  // Names that random requests draw from. Half of them use a four-letter
  // alphabet so that names share prefixes and differ only late.
  logic [63:0] pool_name[POOL_SIZE];
  int          pool_len[POOL_SIZE];

  // When set, the sender issues back to back for the whole phase.
  bit steady = 1'b0;
  int cycles = 0;

  string_key_hash_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key_name    (in_key_name),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_handle_out (out_handle_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A request beat is taken at an edge where start is high and busy is low.
  // Reading the signals here sees their values from before the edge, which
  // are exactly the ones the block samples.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
      sb.note_request(skht_pkg::action_t'(in_action), in_key_name, in_handle_in);
  end

  // The receiver cannot stall, so every cycle with out_valid high is a result.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_reply(out_status, out_slot_index, out_handle_out);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, sb.pending.size());
      $display("string_key_hash_table verification failed");
      $finish;
    end
  end

  // Presents one request and returns right after the edge that takes it.
  // The caller is always just past a rising edge when it calls this.
  task automatic send(input skht_pkg::action_t act, input logic [63:0] raw,
                      input logic [31:0] hnd);
    start        <= 1'b1;
    in_action    <= act;
    in_key_name  <= raw;
    in_handle_in <= hnd;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Mostly no gap or a short one, now and then a long one, so that idle
  // cycles land in every phase of a request: hashing, modulo and probing.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input skht_pkg::action_t act, input logic [63:0] raw,
                       input logic [31:0] hnd);
    int gap;
    send(act, raw, hnd);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Returns the nth short name whose home slot is the target. Used to set up
  // collisions and probe chains that wrap from the last slot to slot zero.
  function automatic logic [63:0] name_at_home(input int target, input int nth);
    logic [63:0] cand;
    int unsigned home;
    int          hits;
    hits = 0;
    cand = '0;
    for (int i = 0; i < 6760; i++) begin
      cand = {8'h6b, 8'(8'h41 + i % 26), 8'(8'h41 + (i / 26) % 26),
              8'(8'h30 + i / 676), 32'h0};
      void'(sb.trim_name(cand, home));
      if (home == target) begin
        if (hits == nth) return cand;
        hits++;
      end
    end
    return cand;
  endfunction

  // A pool name, for names under seven bytes half the time with random bytes after its terminating zero.
  // Those bytes must not change which entry the request matches.
  function automatic logic [63:0] dressed_name(input int idx);
    logic [63:0] raw;
    int          len;
    raw = pool_name[idx];
    len = pool_len[idx];
    if (len < 7 && $urandom_range(0, 1) == 1)
      raw |= {$urandom, $urandom} & ((64'h1 << (8 * (7 - len))) - 64'h1);
    return raw;
  endfunction

  task automatic run_phase(input int count, input int p_ins, input int p_rem);
    int                r;
    skht_pkg::action_t act;
    logic [63:0]       raw;
    steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < p_ins) act = skht_pkg::ACT_INSERT;
      else if (r < p_ins + p_rem) act = skht_pkg::ACT_REMOVE;
      else if (r < 97) act = skht_pkg::ACT_FIND;
      else act = skht_pkg::ACT_NONE;
      r = $urandom_range(0, 99);
      if (r < 85) raw = dressed_name($urandom_range(0, POOL_SIZE - 1));
      else if (r < 95) raw = {$urandom, $urandom};
      else raw = {8'h00, 24'($urandom), $urandom};
      issue(act, raw, $urandom);
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [63:0] pair_a;
    logic [63:0] pair_b;
    logic [63:0] wrap_a;
    logic [63:0] wrap_b;
    logic [63:0] name;
    int          len;
    int          drain;

    for (int i = 0; i < POOL_SIZE; i++) begin
      name = '0;
      len  = $urandom_range(1, 8);
      for (int b = 0; b < len; b++)
        name[63-8*b -: 8] = (i % 2 == 0) ? 8'(8'h61 + $urandom_range(0, 3))
                                         : 8'($urandom_range(1, 255));
      pool_name[i] = name;
      pool_len[i]  = len;
    end
    pair_a = name_at_home(40, 0);
    pair_b = name_at_home(40, 1);
    wrap_a = name_at_home(SLOTS - 1, 0);
    wrap_b = name_at_home(SLOTS - 1, 1);

    // Hold the synchronous reset, then release it and let the block leave
    // reset. Its clearing sweep keeps busy high, and the first send simply
    // waits that out.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The empty name hashes to zero and is a key like any
    // other; trailing bytes after a zero byte are ignored.
    issue(skht_pkg::ACT_INSERT, 64'h0, 32'hffff_ffff);
    issue(skht_pkg::ACT_FIND, 64'h00a5_5a5a_5a5a_5a5a, 32'h0);
    issue(skht_pkg::ACT_INSERT, 64'h005a_a5a5_0000_0001, 32'h1234_5678);
    issue(skht_pkg::ACT_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0);
    issue(skht_pkg::ACT_FIND, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    issue(skht_pkg::ACT_INSERT, 64'h6162_0033_4455_6677, 32'h8000_0001);
    issue(skht_pkg::ACT_FIND, 64'h6162_0000_0000_0000, 32'h0);
    // The unused action code changes nothing and reports not found.
    issue(skht_pkg::ACT_NONE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    issue(skht_pkg::ACT_REMOVE, 64'h7a7a_7a00_0000_0000, 32'h0);
    issue(skht_pkg::ACT_FIND, 64'h7a7a_7a00_0000_0000, 32'h0);
    // Two names with one home: the second lands one slot further on. With
    // no tombstone, removing the first hides the second from later lookups.
    issue(skht_pkg::ACT_INSERT, pair_a, 32'h0000_00a1);
    issue(skht_pkg::ACT_INSERT, pair_b, 32'h0000_00b2);
    issue(skht_pkg::ACT_REMOVE, pair_a, 32'h0);
    issue(skht_pkg::ACT_FIND, pair_b, 32'h0);
    issue(skht_pkg::ACT_REMOVE, pair_b, 32'h0);
    issue(skht_pkg::ACT_INSERT, pair_b, 32'h0000_00c3);
    issue(skht_pkg::ACT_FIND, pair_b, 32'h0);
    // A chain that starts in the last slot wraps around to the first ones.
    issue(skht_pkg::ACT_INSERT, wrap_a, 32'h5555_aaaa);
    issue(skht_pkg::ACT_INSERT, wrap_b, 32'haaaa_5555);
    issue(skht_pkg::ACT_FIND, wrap_b, 32'h0);
    issue(skht_pkg::ACT_REMOVE, wrap_b, 32'h0);
    issue(skht_pkg::ACT_REMOVE, wrap_a, 32'h0);
    issue(skht_pkg::ACT_REMOVE, 64'h0, 32'h0);

    // Random part. Each round fills the table until inserts report full and
    // lookups of absent names run a whole turn, then mixes, then thins it.
    for (int round = 0; round < 4; round++) begin
      run_phase(280, 80, 8);
      run_phase(70, 35, 30);
      run_phase(50, 10, 70);
    end

    start <= 1'b0;
    drain = 0;
    while (sb.pending.size() != 0 && drain < 4 * SETTLE) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end

    $display("Requests taken: %0d insert, %0d remove, %0d find, %0d unused code",
             sb.act_count[skht_pkg::ACT_INSERT], sb.act_count[skht_pkg::ACT_REMOVE],
             sb.act_count[skht_pkg::ACT_FIND], sb.act_count[skht_pkg::ACT_NONE]);
    $display("Results seen: %0d ok, %0d not found, %0d full, %0d duplicate, %0d errors",
             sb.status_seen[skht_pkg::STS_OK], sb.status_seen[skht_pkg::STS_NOT_FOUND],
             sb.status_seen[skht_pkg::STS_FULL], sb.status_seen[skht_pkg::STS_DUPLICATE],
             sb.errors);
    if (sb.errors == 0) begin
      $display("string_key_hash_table verification clean");
    end else begin
      $display("string_key_hash_table verification failed");
    end
    $finish;
  end

endmodule

>>> string_key_hash_table.f
hw/rtl/skht_pkg.sv
hw/rtl/skht_home_unit.sv
hw/rtl/string_key_hash_table.sv
test/tb.sv
